### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; expect clk and arst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define BTMX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define BTMX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// Types and constants shared by the binary trie max-xor core.
// ----------------------------------------------------------------------------
package btmx_pkg;

	// Width of the key and result ports
	localparam int KEY_W = 32;

	// Command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // latch a new word, launch the root read
		logic step;    // walk one trie level
		logic finish;  // register the result, strobe next cycle
	} btmx_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic refuse;  // insert offered while too few free nodes remain
	} btmx_sts_t;

endpackage

### design/btmx_ram.sv
// ----------------------------------------------------------------------------
// btmx_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module btmx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/btmx_ctrl.sv
// ----------------------------------------------------------------------------
// btmx_ctrl
// Sequencer: accepts a word, counts the trie levels, signals the finish.
// ----------------------------------------------------------------------------
module btmx_ctrl #(
	parameter int KEY_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  btmx_pkg::btmx_sts_t  sts,
	output btmx_pkg::btmx_ctl_t  ctl
);

	import btmx_pkg::*;

	localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic          state_q;
	logic [LW-1:0] lvl_q;
	logic          last_lvl;

	assign busy     = (state_q == ST_WALK);
	assign last_lvl = (lvl_q == '0);

	always_comb begin
		ctl.load   = start & ~busy;
		ctl.step   = busy;
		ctl.finish = (busy & last_lvl) | (ctl.load & sts.refuse);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.load && !sts.refuse) begin
						state_q <= ST_WALK;
						lvl_q   <= LW'(KEY_BITS - 1);
					end
				end
				ST_WALK: begin
					if (last_lvl) begin
						state_q <= ST_IDLE;
					end else begin
						lvl_q <= lvl_q - LW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/btmx_dpath.sv
// ----------------------------------------------------------------------------
// btmx_dpath
// Trie walk datapath: link store, walk registers, node allocator, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btmx_dpath #(
	parameter int KEY_BITS      = 32,
	parameter int NODE_CAPACITY = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          command,
	input  logic [btmx_pkg::KEY_W-1:0]    key,
	input  btmx_pkg::btmx_ctl_t           ctl,
	output btmx_pkg::btmx_sts_t           sts,
	output logic                          done,
	output logic [btmx_pkg::KEY_W-1:0]    max_xor,
	output logic                          store_full
);

	import btmx_pkg::*;

	localparam int NW = $clog2(NODE_CAPACITY);
	localparam int KB = KEY_BITS;
	localparam int SW = NW + 8;

	// walk state
	logic [KB-1:0] key_q;
	logic [KB-1:0] acc_q;
	logic          cmd_q;
	logic [NW-1:0] pos_q;
	logic          fresh_q;  // current node is new or the empty root: row is empty
	logic [NW-1:0] nc_q;     // last allocated node

	// result
	logic             done_q;
	logic [KEY_W-1:0] max_xor_q;
	logic             store_full_q;

	logic [KB-1:0]     key_ext;
	logic [KB-1:0]     acc_nx;
	logic [KEY_W-1:0]  acc_lo;
	logic [2*NW-1:0]   rd_data;
	logic [2*NW-1:0]   row;
	logic [NW-1:0]     lnk0, lnk1, opp, same, new_node, next_pos;
	logic              bit_k, take_opp, ins_alloc;
	logic              we, rd_en;
	logic [NW-1:0]     rd_addr;
	logic [2*NW-1:0]   wr_data;

	generate
		if (KB >= KEY_W) begin : g_wide
			assign key_ext = KB'(key);
			assign acc_lo  = acc_nx[KEY_W-1:0];
		end else begin : g_narrow
			assign key_ext = key[KB-1:0];
			assign acc_lo  = KEY_W'(acc_nx);
		end
	endgenerate

	// free-node check: refuse when nc + KEY_BITS > NODE_CAPACITY - 1
	assign sts.refuse = (command == CMD_INSERT) &&
		((SW'(nc_q) + SW'(KEY_BITS)) >= SW'(NODE_CAPACITY));

	// per-level link selection
	always_comb begin
		row       = fresh_q ? '0 : rd_data;
		lnk0      = row[NW-1:0];
		lnk1      = row[2*NW-1:NW];
		bit_k     = key_q[KB-1];
		opp       = bit_k ? lnk0 : lnk1;
		same      = bit_k ? lnk1 : lnk0;
		take_opp  = (cmd_q == CMD_QUERY) && (opp != '0);
		ins_alloc = (cmd_q == CMD_INSERT) && (same == '0);
		new_node  = nc_q + NW'(1);
		if (take_opp) begin
			next_pos = opp;
		end else if (ins_alloc) begin
			next_pos = new_node;
		end else begin
			next_pos = same;
		end
		acc_nx  = (acc_q << 1) | KB'(take_opp);
		rd_en   = ctl.load | ctl.step;
		rd_addr = ctl.load ? '0 : next_pos;
		we      = ctl.step & ins_alloc;
		wr_data = bit_k ? {new_node, lnk0} : {lnk1, new_node};
	end

	btmx_ram #(
		.WIDTH (2 * NW),
		.DEPTH (NODE_CAPACITY)
	) u_links (
		.clk     (clk),
		.we      (we),
		.wr_addr (pos_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// walk payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= key_ext;
			cmd_q <= command;
			pos_q <= '0;
			acc_q <= '0;
		end else if (ctl.step) begin
			key_q <= key_q << 1;
			pos_q <= next_pos;
			acc_q <= acc_nx;
		end
		if (ctl.finish) begin
			max_xor_q    <= ctl.load ? '0 : acc_lo;
			store_full_q <= ctl.load;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q    <= '0;
			fresh_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.finish;
			if (ctl.load) begin
				fresh_q <= (nc_q == '0);
			end else if (ctl.step && ins_alloc) begin
				fresh_q <= 1'b1;
				nc_q    <= new_node;
			end
		end
	end

	assign done       = done_q;
	assign max_xor    = max_xor_q;
	assign store_full = store_full_q;

	`BTMX_ASSERT(a_nc_monotonic, ##1 (nc_q >= $past(nc_q)), "node count went backwards")
	`BTMX_ASSERT_NEXT(a_write_allocs, we, nc_q == $past(nc_q) + NW'(1), "link write without allocation")
	`BTMX_ASSERT_NEXT(a_refuse_full, ctl.load && sts.refuse, done_q && store_full_q, "refused insert not reported")

endmodule

### design/binary_trie_max_xor_core.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor_core
// Binary trie of keys with insert and maximum-xor query commands.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | handshake
//  --------+-------------------------------+-------------------------------
//  command | command, key                  | start & !busy accepts a word
//  result  | max_xor, store_full           | done, one cycle, no backpressure
//
//  Flow: a word is accepted, then walked with one link read per trie level
//  on the single read port of the link store.
//  A refused insert (full store) finishes in its accept cycle, without a walk.
//  done is high in the cycle after the last level; busy is already low there,
//  so the next word can be accepted in the same cycle.
//  Reset clears node count and control; link rows need no clearing pass,
//  since a row is used only after it was written (new path rows read as empty).
//  The receiver cannot stall: a result is valid for exactly one cycle.
//
module binary_trie_max_xor_core #(
	parameter int KEY_BITS      = 32,
	parameter int NODE_CAPACITY = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic [btmx_pkg::KEY_W-1:0] key,
	output logic                       done,
	output logic [btmx_pkg::KEY_W-1:0] max_xor,
	output logic                       store_full
);

	import btmx_pkg::*;

	btmx_ctl_t ctl;
	btmx_sts_t sts;

	// sequencer: level counter and word accept
	btmx_ctrl #(
		.KEY_BITS (KEY_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	// link store, walk registers and result registers
	btmx_dpath #(
		.KEY_BITS      (KEY_BITS),
		.NODE_CAPACITY (NODE_CAPACITY)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (command),
		.key        (key),
		.ctl        (ctl),
		.sts        (sts),
		.done       (done),
		.max_xor    (max_xor),
		.store_full (store_full)
	);

endmodule
